/* sv/pmbd_pkg.sv */
// pmbd_pkg: shared constants, register codes and types for the palette map box downsampler.
// No dependencies; every other file but pmbd_colsum_ram takes names from here by scope.
package pmbd_pkg;

    localparam int MAX_WIDTH_DEF     = 2048;
    localparam int PALETTE_DEPTH_DEF = 4096;
    localparam int MAX_FACTOR_DEF    = 8;

    localparam int INDEX_W  = 12;
    localparam int COLOR_W  = 24;
    localparam int CHAN_W   = 8;
    localparam int FACTOR_W = 4;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W    = 13;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    typedef enum logic [1:0] {
        REG_FACTOR     = 2'd0,
        REG_OUT_WIDTH  = 2'd1,
        REG_OUT_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic first;
        logic emit;
        logic row_end;
        logic frame_end;
    } t_step_info;

    function automatic int sum_width(input int max_factor);
        return CHAN_W + 2 * $clog2(max_factor);
    endfunction

endpackage

/* sv/palette_map_box_downsample.sv */
// On accepting an escape-time sample the block reads the palette entry and the column's
// running sums from their memories; in the work state it writes the updated sums back and,
// on the last sample of a factor-by-factor block, loads the averaged pixel into the output
// register. The input is stalled for the whole work state (the column-sum read-modify-write
// interlock), which lasts longer while a finished pixel waits in a full output register.
// Palette writes do not stall the input; config register writes restart the frame position.
// Top level: palette_map_box_downsample. Uses pmbd_pkg, pmbd_palette_ram, pmbd_colsum_ram,
// pmbd_position and pmbd_accum.
module palette_map_box_downsample #(
    parameter int MAX_WIDTH     = pmbd_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = pmbd_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_FACTOR    = pmbd_pkg::MAX_FACTOR_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pmbd_pkg::APB_AW-1:0]  paddr,
    input  logic [pmbd_pkg::APB_DW-1:0]  pwdata,
    output logic [pmbd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [pmbd_pkg::INDEX_W-1:0] i_palette_index,
    input  logic [pmbd_pkg::COLOR_W-1:0] i_palette_color,
    input  logic [pmbd_pkg::INDEX_W-1:0] i_escape_time,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [pmbd_pkg::CHAN_W-1:0]  o_blue,
    output logic [pmbd_pkg::CHAN_W-1:0]  o_green,
    output logic [pmbd_pkg::CHAN_W-1:0]  o_red,
    output logic                         o_row_end,
    output logic                         o_frame_end
);
    localparam int FW     = $clog2(MAX_FACTOR + 1);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CHW    = pmbd_pkg::sum_width(MAX_FACTOR);
    localparam int SUMS_W = 3 * CHW;
    localparam int CH     = pmbd_pkg::CHAN_W;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } t_state;

    t_state                          r_state;
    logic [pmbd_pkg::FACTOR_W-1:0]   r_factor;
    logic [pmbd_pkg::WIDTH_W-1:0]    r_out_width;
    logic [pmbd_pkg::HEIGHT_W-1:0]   r_out_height;
    pmbd_pkg::t_step_info            r_info;
    logic [CW-1:0]                   r_wcol;
    logic                            r_out_valid;
    logic [CH-1:0]                   r_blue, r_green, r_red;
    logic                            r_row_end, r_frame_end;

    pmbd_pkg::t_reg_idx              w_reg;
    logic                            w_cfg_wr, w_cfg_hit, w_restart;
    logic [FW-1:0]                   w_factor;
    logic [WW-1:0]                   w_width;
    logic [pmbd_pkg::HEIGHT_W-1:0]   w_height;
    logic                            w_in_acc, w_sample, w_pal_wr, w_finish;
    logic [CW-1:0]                   w_column;
    pmbd_pkg::t_step_info            w_info;
    logic [pmbd_pkg::COLOR_W-1:0]    w_color;
    logic [SUMS_W-1:0]               w_old_sums, w_new_sums;
    logic [CH-1:0]                   w_blue, w_green, w_red;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg     = pmbd_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_restart = w_cfg_wr && w_cfg_hit;

    always_comb begin
        w_cfg_hit = 1'b0;
        prdata    = '0;
        case (w_reg)
            pmbd_pkg::REG_FACTOR: begin
                w_cfg_hit = 1'b1;
                prdata    = pmbd_pkg::APB_DW'(r_factor);
            end
            pmbd_pkg::REG_OUT_WIDTH: begin
                w_cfg_hit = 1'b1;
                prdata    = pmbd_pkg::APB_DW'(r_out_width);
            end
            pmbd_pkg::REG_OUT_HEIGHT: begin
                w_cfg_hit = 1'b1;
                prdata    = pmbd_pkg::APB_DW'(r_out_height);
            end
            default: begin
                w_cfg_hit = 1'b0;
                prdata    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor     <= pmbd_pkg::FACTOR_W'(1);
            r_out_width  <= pmbd_pkg::WIDTH_W'(1);
            r_out_height <= pmbd_pkg::HEIGHT_W'(1);
        end else if (w_cfg_wr) begin
            case (w_reg)
                pmbd_pkg::REG_FACTOR:     r_factor     <= pwdata[pmbd_pkg::FACTOR_W-1:0];
                pmbd_pkg::REG_OUT_WIDTH:  r_out_width  <= pwdata[pmbd_pkg::WIDTH_W-1:0];
                pmbd_pkg::REG_OUT_HEIGHT: r_out_height <= pwdata[pmbd_pkg::HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        if (r_factor == '0) begin
            w_factor = FW'(1);
        end else if (32'(r_factor) > 32'(MAX_FACTOR)) begin
            w_factor = FW'(MAX_FACTOR);
        end else begin
            w_factor = FW'(r_factor);
        end
        if (r_out_width == '0) begin
            w_width = WW'(1);
        end else if (32'(r_out_width) > 32'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_out_width);
        end
        w_height = (r_out_height == '0) ? pmbd_pkg::HEIGHT_W'(1) : r_out_height;
    end

    // input handshake
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_sample   = w_in_acc && i_operation;
    assign w_pal_wr   = w_in_acc && !i_operation;
    assign w_finish   = (r_state == ST_WORK) && (!r_info.emit || !r_out_valid || !i_out_stall);

    pmbd_palette_ram #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk    (i_clk),
        .i_we     (w_pal_wr),
        .i_windex (i_palette_index),
        .i_wcolor (i_palette_color),
        .i_re     (w_sample),
        .i_rindex (i_escape_time),
        .o_color  (w_color)
    );

    pmbd_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_advance (w_sample),
        .i_factor  (w_factor),
        .i_width   (w_width),
        .i_height  (w_height),
        .o_column  (w_column),
        .o_info    (w_info)
    );

    pmbd_colsum_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SUMS_W)
    ) u_colsum (
        .i_clk   (i_clk),
        .i_we    (w_finish),
        .i_waddr (r_wcol),
        .i_wdata (w_new_sums),
        .i_re    (w_sample),
        .i_raddr (w_column),
        .o_rdata (w_old_sums)
    );

    pmbd_accum #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_accum (
        .i_color  (w_color),
        .i_sums   (w_old_sums),
        .i_first  (r_info.first),
        .i_factor (w_factor),
        .o_sums   (w_new_sums),
        .o_blue   (w_blue),
        .o_green  (w_green),
        .o_red    (w_red)
    );

    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_info <= w_info;
            r_wcol <= w_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_sample) begin
                        r_state <= ST_WORK;
                    end
                end
                ST_WORK: begin
                    if (w_finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_finish && r_info.emit) begin
                r_out_valid <= 1'b1;
                r_blue      <= w_blue;
                r_green     <= w_green;
                r_red       <= w_red;
                r_row_end   <= r_info.row_end;
                r_frame_end <= r_info.frame_end;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_blue      = r_blue;
    assign o_green     = r_green;
    assign o_red       = r_red;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

endmodule

/* sv/pmbd_palette_ram.sv */
// pmbd_palette_ram: palette store, one write and one registered read port.
// Indexes beyond the depth are dropped on write and read as black. Uses pmbd_pkg.
module pmbd_palette_ram #(
    parameter int PALETTE_DEPTH = pmbd_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [pmbd_pkg::INDEX_W-1:0] i_windex,
    input  logic [pmbd_pkg::COLOR_W-1:0] i_wcolor,
    input  logic                         i_re,
    input  logic [pmbd_pkg::INDEX_W-1:0] i_rindex,
    output logic [pmbd_pkg::COLOR_W-1:0] o_color
);
    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [pmbd_pkg::COLOR_W-1:0] r_mem [PALETTE_DEPTH];
    logic [pmbd_pkg::COLOR_W-1:0] r_rdata;
    logic                         r_rhit;
    logic [31:0]                  w_widx;
    logic [31:0]                  w_ridx;

    assign w_widx = 32'(i_windex);
    assign w_ridx = 32'(i_rindex);

    always_ff @(posedge i_clk) begin
        if (i_we && (w_widx < 32'(PALETTE_DEPTH))) begin
            r_mem[w_widx[AW-1:0]] <= i_wcolor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[w_ridx[AW-1:0]];
            r_rhit  <= (w_ridx < 32'(PALETTE_DEPTH));
        end
    end

    assign o_color = r_rhit ? r_rdata : '0;

endmodule

/* sv/pmbd_colsum_ram.sv */
// pmbd_colsum_ram: line of per-column channel sums, one write and one registered read port.
// Depends on nothing but its parameters.
module pmbd_colsum_ram #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 42
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pmbd_position.sv */
// pmbd_position: raster position counters over the supersampled frame and per-sample flags.
// Uses pmbd_pkg for widths and the step info struct.
module pmbd_position #(
    parameter int MAX_WIDTH  = pmbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = pmbd_pkg::MAX_FACTOR_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_restart,
    input  logic                                i_advance,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]     i_factor,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_width,
    input  logic [pmbd_pkg::HEIGHT_W-1:0]       i_height,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_column,
    output pmbd_pkg::t_step_info                o_info
);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int SW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = pmbd_pkg::ROW_W;

    logic [SW-1:0] r_sub_col, n_sub_col;
    logic [SW-1:0] r_sub_row, n_sub_row;
    logic [CW-1:0] r_column,  n_column;
    logic [RW-1:0] r_row,     n_row;
    logic          w_last_sc, w_last_col, w_last_sr, w_last_row;

    assign w_last_sc  = ((FW+1)'(r_sub_col) + (FW+1)'(1)) >= (FW+1)'(i_factor);
    assign w_last_sr  = ((FW+1)'(r_sub_row) + (FW+1)'(1)) >= (FW+1)'(i_factor);
    assign w_last_col = ((WW+1)'(r_column) + (WW+1)'(1)) >= (WW+1)'(i_width);
    assign w_last_row = ((RW+1)'(r_row) + (RW+1)'(1)) >= (RW+1)'(i_height);

    always_comb begin
        n_sub_col = r_sub_col;
        n_sub_row = r_sub_row;
        n_column  = r_column;
        n_row     = r_row;
        if (!w_last_sc) begin
            n_sub_col = r_sub_col + SW'(1);
        end else begin
            n_sub_col = '0;
            if (!w_last_col) begin
                n_column = r_column + CW'(1);
            end else begin
                n_column = '0;
                if (!w_last_sr) begin
                    n_sub_row = r_sub_row + SW'(1);
                end else begin
                    n_sub_row = '0;
                    n_row     = w_last_row ? '0 : r_row + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_sub_col <= '0;
            r_sub_row <= '0;
            r_column  <= '0;
            r_row     <= '0;
        end else if (i_advance) begin
            r_sub_col <= n_sub_col;
            r_sub_row <= n_sub_row;
            r_column  <= n_column;
            r_row     <= n_row;
        end
    end

    assign o_column         = r_column;
    assign o_info.first     = (r_sub_row == '0) && (r_sub_col == '0);
    assign o_info.emit      = w_last_sc && w_last_sr;
    assign o_info.row_end   = w_last_col;
    assign o_info.frame_end = w_last_col && w_last_row;

endmodule

/* sv/pmbd_accum.sv */
// pmbd_accum: adds a palette color into a column's channel sums and averages by factor squared.
// Division is a multiply by a per-factor reciprocal. Uses pmbd_pkg.
module pmbd_accum #(
    parameter int MAX_FACTOR = pmbd_pkg::MAX_FACTOR_DEF
) (
    input  logic [pmbd_pkg::COLOR_W-1:0]                        i_color,
    input  logic [3*pmbd_pkg::sum_width(MAX_FACTOR)-1:0]        i_sums,
    input  logic                                                i_first,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]                     i_factor,
    output logic [3*pmbd_pkg::sum_width(MAX_FACTOR)-1:0]        o_sums,
    output logic [pmbd_pkg::CHAN_W-1:0]                         o_blue,
    output logic [pmbd_pkg::CHAN_W-1:0]                         o_green,
    output logic [pmbd_pkg::CHAN_W-1:0]                         o_red
);
    localparam int CHW = pmbd_pkg::sum_width(MAX_FACTOR);
    localparam int LF  = $clog2(MAX_FACTOR);
    localparam int S   = CHW + 2 * LF;
    localparam int RCW = S + 1;
    localparam int PW  = CHW + RCW;
    localparam int CH  = pmbd_pkg::CHAN_W;

    logic [RCW-1:0] w_recip [MAX_FACTOR+1];
    logic [CH-1:0]  w_chan  [3];
    logic [CHW-1:0] w_old   [3];
    logic [CHW-1:0] w_new   [3];
    logic [PW-1:0]  w_prod  [3];
    logic [CH-1:0]  w_avg   [3];

    // ceil(2^S / f^2): exact floor division for every sum below 2^CHW
    for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_recip
        localparam longint unsigned D = (g == 0) ? 1 : g * g;
        localparam longint unsigned M = ((64'd1 << S) + D - 1) / D;
        assign w_recip[g] = RCW'(M);
    end

    assign w_chan[0] = i_color[2*CH +: CH];
    assign w_chan[1] = i_color[CH +: CH];
    assign w_chan[2] = i_color[0 +: CH];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_old[k]  = i_sums[k*CHW +: CHW];
            w_new[k]  = i_first ? CHW'(w_chan[k]) : w_old[k] + CHW'(w_chan[k]);
            w_prod[k] = PW'(w_new[k]) * PW'(w_recip[i_factor]);
            w_avg[k]  = w_prod[k][S +: CH];
        end
    end

    assign o_sums  = {w_new[2], w_new[1], w_new[0]};
    assign o_blue  = w_avg[0];
    assign o_green = w_avg[1];
    assign o_red   = w_avg[2];

endmodule

/* sv/pmbd_checker.sv */
// pmbd_checker: port-level assertions for palette_map_box_downsample, bound to the top level.
// Depends on the top level's port names and on pmbd_pkg for the channel width.
module pmbd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        pready,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_operation,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [pmbd_pkg::CHAN_W-1:0] o_blue,
    input logic [pmbd_pkg::CHAN_W-1:0] o_green,
    input logic [pmbd_pkg::CHAN_W-1:0] o_red,
    input logic                        o_row_end,
    input logic                        o_frame_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid &&
            $stable({o_blue, o_green, o_red, o_row_end, o_frame_end})))
        else $error("stalled output word changed");

    a_sample_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_operation) |=> o_in_stall)
        else $error("sample accepted during column-sum update");

    a_palette_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_operation) |=> !o_in_stall)
        else $error("palette write stalled the input");

    a_frame_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind palette_map_box_downsample pmbd_checker u_pmbd_checker (.*);

/* verif/palette_map_box_downsample_tb.sv */
// palette_map_box_downsample_tb: self-checking bench for the palette map box downsampler.
// Loads the palette, streams escape-time words over many register settings and checks each
// averaged pixel against an in-bench model. Depends on pmbd_pkg and the block's RTL.
`timescale 1ns / 1ps

module palette_map_box_downsample_tb;

    localparam bit OP_PAL_WRITE  = 1'b0;
    localparam bit OP_SAMPLE     = 1'b1;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 400;
    localparam int DIR_ROWS      = 14;

    typedef struct packed {
        logic [pmbd_pkg::CHAN_W-1:0] blue;
        logic [pmbd_pkg::CHAN_W-1:0] green;
        logic [pmbd_pkg::CHAN_W-1:0] red;
        logic                        row_end;
        logic                        frame_end;
    } t_pixel;

    typedef struct packed {
        logic                         op;
        logic [pmbd_pkg::INDEX_W-1:0] pal_idx;
        logic [pmbd_pkg::COLOR_W-1:0] color;
        logic [pmbd_pkg::INDEX_W-1:0] esc;
        logic                         known;
        t_pixel                       px;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [pmbd_pkg::APB_AW-1:0]   paddr = '0;
    logic [pmbd_pkg::APB_DW-1:0]   pwdata = '0;
    logic [pmbd_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_operation = 1'b0;
    logic [pmbd_pkg::INDEX_W-1:0]  i_palette_index = '0;
    logic [pmbd_pkg::COLOR_W-1:0]  i_palette_color = '0;
    logic [pmbd_pkg::INDEX_W-1:0]  i_escape_time = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [pmbd_pkg::CHAN_W-1:0]   o_blue;
    logic [pmbd_pkg::CHAN_W-1:0]   o_green;
    logic [pmbd_pkg::CHAN_W-1:0]   o_red;
    logic                          o_row_end;
    logic                          o_frame_end;

    // directed words: reset setting is 1x1x1, so every sample is a full frame
    t_dir_row dir_tab [0:DIR_ROWS-1] = '{
        {OP_PAL_WRITE, 12'h000, 24'h000000, 12'hfff, 1'b0, 26'h0},
        {OP_PAL_WRITE, 12'hfff, 24'hffffff, 12'h000, 1'b0, 26'h0},
        {OP_PAL_WRITE, 12'h555, 24'h123456, 12'haaa, 1'b0, 26'h0},
        {OP_PAL_WRITE, 12'haaa, 24'ha5c30f, 12'h555, 1'b0, 26'h0},
        {OP_SAMPLE,    12'hfff, 24'hffffff, 12'h000, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
        {OP_SAMPLE,    12'h000, 24'h000000, 12'hfff, 1'b1, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1},
        {OP_SAMPLE,    12'h000, 24'h000000, 12'h555, 1'b1, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1},
        {OP_SAMPLE,    12'h000, 24'h000000, 12'haaa, 1'b1, 8'ha5, 8'hc3, 8'h0f, 1'b1, 1'b1},
        {OP_PAL_WRITE, 12'hfff, 24'h000000, 12'h000, 1'b0, 26'h0},
        {OP_SAMPLE,    12'h000, 24'h000000, 12'hfff, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
        {OP_PAL_WRITE, 12'h800, 24'h80ff01, 12'h000, 1'b0, 26'h0},
        {OP_SAMPLE,    12'h000, 24'h000000, 12'h800, 1'b1, 8'h80, 8'hff, 8'h01, 1'b1, 1'b1},
        {OP_PAL_WRITE, 12'h7ff, 24'h7f00fe, 12'h000, 1'b0, 26'h0},
        {OP_SAMPLE,    12'h000, 24'h000000, 12'h7ff, 1'b0, 26'h0}
    };

    // model state
    logic [pmbd_pkg::COLOR_W-1:0]  pal_mem    [0:pmbd_pkg::PALETTE_DEPTH_DEF-1];
    bit                            pal_loaded [0:pmbd_pkg::PALETTE_DEPTH_DEF-1];
    int                            pal_used_q [$];
    int unsigned                   sum_b [0:pmbd_pkg::MAX_WIDTH_DEF-1];
    int unsigned                   sum_g [0:pmbd_pkg::MAX_WIDTH_DEF-1];
    int unsigned                   sum_r [0:pmbd_pkg::MAX_WIDTH_DEF-1];
    int unsigned                   sub_col, col, sub_row, row;
    logic [pmbd_pkg::FACTOR_W-1:0] cfg_factor = 4'd1;
    logic [pmbd_pkg::WIDTH_W-1:0]  cfg_width = 12'd1;
    logic [pmbd_pkg::HEIGHT_W-1:0] cfg_height = 13'd1;
    t_pixel                        pending_pixels [$];

    int fails = 0;
    int cycles = 0;
    int n_loads = 0;
    int n_samples = 0;
    int n_pixels = 0;
    int n_settings = 0;
    int gap_max = 10;
    int stall_max = 10;

    palette_map_box_downsample dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_escape_time   (i_escape_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_blue          (o_blue),
        .o_green         (o_green),
        .o_red           (o_red),
        .o_row_end       (o_row_end),
        .o_frame_end     (o_frame_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels pending", cycles,
                     pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned clamp_factor(input logic [pmbd_pkg::FACTOR_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > pmbd_pkg::MAX_FACTOR_DEF) return pmbd_pkg::MAX_FACTOR_DEF;
        return raw;
    endfunction

    function automatic int unsigned clamp_width(input logic [pmbd_pkg::WIDTH_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > pmbd_pkg::MAX_WIDTH_DEF) return pmbd_pkg::MAX_WIDTH_DEF;
        return raw;
    endfunction

    function automatic int unsigned clamp_height(input logic [pmbd_pkg::HEIGHT_W-1:0] raw);
        return (raw == 0) ? 1 : raw;
    endfunction

    function automatic void load_palette(input logic [pmbd_pkg::INDEX_W-1:0] idx,
                                         input logic [pmbd_pkg::COLOR_W-1:0] color);
        pal_mem[idx] = color;
        if (!pal_loaded[idx]) begin
            pal_loaded[idx] = 1'b1;
            pal_used_q.push_back(idx);
        end
    endfunction

    // box-filter one sample into its column; returns 1 when a block completes
    function automatic bit box_filter_step(input logic [pmbd_pkg::INDEX_W-1:0] esc,
                                           output t_pixel px);
        int unsigned                  f, w, h, div;
        logic [pmbd_pkg::COLOR_W-1:0] c;
        bit                           last_sc, last_col, last_sr, last_row, done;
        f = clamp_factor(cfg_factor);
        w = clamp_width(cfg_width);
        h = clamp_height(cfg_height);
        c = pal_mem[esc];
        px = '0;
        done = 1'b0;
        if (col >= pmbd_pkg::MAX_WIDTH_DEF) col = 0;
        if (sub_row == 0 && sub_col == 0) begin
            sum_b[col] = c[23:16];
            sum_g[col] = c[15:8];
            sum_r[col] = c[7:0];
        end else begin
            sum_b[col] += c[23:16];
            sum_g[col] += c[15:8];
            sum_r[col] += c[7:0];
        end
        last_sc  = (sub_col + 1 >= f);
        last_col = (col + 1 >= w);
        last_sr  = (sub_row + 1 >= f);
        last_row = (row + 1 >= h);
        if (last_sc && last_sr) begin
            div = f * f;
            px.blue      = pmbd_pkg::CHAN_W'(sum_b[col] / div);
            px.green     = pmbd_pkg::CHAN_W'(sum_g[col] / div);
            px.red       = pmbd_pkg::CHAN_W'(sum_r[col] / div);
            px.row_end   = last_col;
            px.frame_end = last_col && last_row;
            done = 1'b1;
        end
        if (!last_sc) begin
            sub_col++;
        end else begin
            sub_col = 0;
            if (!last_col) begin
                col++;
            end else begin
                col = 0;
                if (!last_sr) begin
                    sub_row++;
                end else begin
                    sub_row = 0;
                    row = last_row ? 0 : row + 1;
                end
            end
        end
        return done;
    endfunction

    task automatic push_word(input logic op, input logic [pmbd_pkg::INDEX_W-1:0] pal_idx,
                             input logic [pmbd_pkg::COLOR_W-1:0] color,
                             input logic [pmbd_pkg::INDEX_W-1:0] esc,
                             input bit known, input t_pixel want);
        int     gap;
        t_pixel px;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_palette_index <= pal_idx;
        i_palette_color <= color;
        i_escape_time   <= esc;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (op == OP_PAL_WRITE) begin
            load_palette(pal_idx, color);
            n_loads++;
        end else begin
            n_samples++;
            if (box_filter_step(esc, px))
                pending_pixels.push_back(known ? want : px);
        end
    endtask

    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write_reg(input pmbd_pkg::t_reg_idx r,
                                 input logic [pmbd_pkg::APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pmbd_pkg::APB_AW'(4 * int'(r));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            pmbd_pkg::REG_FACTOR:     cfg_factor = val[pmbd_pkg::FACTOR_W-1:0];
            pmbd_pkg::REG_OUT_WIDTH:  cfg_width  = val[pmbd_pkg::WIDTH_W-1:0];
            pmbd_pkg::REG_OUT_HEIGHT: cfg_height = val[pmbd_pkg::HEIGHT_W-1:0];
            default: ;
        endcase
        sub_col = 0;
        col     = 0;
        sub_row = 0;
        row     = 0;
    endtask

    task automatic set_frame(input int f, input int w, input int h);
        drain_pixels();
        apb_write_reg(pmbd_pkg::REG_FACTOR, f);
        apb_write_reg(pmbd_pkg::REG_OUT_WIDTH, w);
        apb_write_reg(pmbd_pkg::REG_OUT_HEIGHT, h);
        n_settings++;
    endtask

    // samples only hit loaded entries; palette loads are mixed in at load_pct percent
    task automatic run_samples(input int n, input int load_pct);
        int                           s;
        logic [pmbd_pkg::COLOR_W-1:0] c;
        logic [pmbd_pkg::INDEX_W-1:0] esc;
        s = 0;
        while (s < n) begin
            if ($urandom_range(0, 99) < load_pct) begin
                case ($urandom_range(0, 7))
                    0:       c = '0;
                    1:       c = '1;
                    default: c = pmbd_pkg::COLOR_W'($urandom);
                endcase
                push_word(OP_PAL_WRITE,
                          pmbd_pkg::INDEX_W'($urandom_range(0,
                                             pmbd_pkg::PALETTE_DEPTH_DEF - 1)),
                          c, pmbd_pkg::INDEX_W'($urandom), 1'b0, '0);
            end else begin
                esc = pmbd_pkg::INDEX_W'(pal_used_q[$urandom_range(0,
                                                    pal_used_q.size() - 1)]);
                push_word(OP_SAMPLE, pmbd_pkg::INDEX_W'($urandom),
                          pmbd_pkg::COLOR_W'($urandom), esc, 1'b0, '0);
                s++;
            end
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic [pmbd_pkg::CHAN_W-1:0] want,
                                        input logic [pmbd_pkg::CHAN_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    // pixel receiver
    initial begin
        int     k;
        t_pixel want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            k = $urandom_range(0, stall_max);
            if (k > 0) begin
                i_out_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel: blue %0h green %0h red %0h", o_blue, o_green, o_red);
                fails++;
            end else begin
                want = pending_pixels.pop_front();
                n_pixels++;
                check_field("blue", want.blue, o_blue);
                check_field("green", want.green, o_green);
                check_field("red", want.red, o_red);
                check_field("row_end", want.row_end, o_row_end);
                check_field("frame_end", want.frame_end, o_frame_end);
            end
        end
    end

    // stimulus
    initial begin
        int f_raw, w_raw, h_raw, frame, n, base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            push_word(dir_tab[k].op, dir_tab[k].pal_idx, dir_tab[k].color, dir_tab[k].esc,
                      dir_tab[k].known, dir_tab[k].px);

        // widest setting at full rate: factor 0 acts as 1, width 4095 as 2048
        gap_max   = 0;
        stall_max = 0;
        set_frame(0, 4095, 2);
        run_samples(200, 0);
        gap_max   = 10;
        stall_max = 10;
        set_frame(15, 2, 1);
        run_samples(256, 5);
        set_frame(1, 1, 8191);
        run_samples(20, 10);
        set_frame(1, 1, 4096);
        run_samples(20, 10);
        set_frame(2, 3, 0);
        run_samples(24, 10);
        set_frame(3, 0, 2);
        run_samples(18, 10);
        set_frame(8, 2048, 4096);
        run_samples(100, 10);

        base = n_loads + n_samples;
        while (n_loads + n_samples - base < RANDOM_WORDS) begin
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            case ($urandom_range(0, 9))
                0:       f_raw = 0;
                1:       f_raw = $urandom_range(pmbd_pkg::MAX_FACTOR_DEF + 1, 15);
                default: f_raw = $urandom_range(1, pmbd_pkg::MAX_FACTOR_DEF);
            endcase
            w_raw = $urandom_range(0, 6);
            h_raw = $urandom_range(0, 4);
            set_frame(f_raw, w_raw, h_raw);
            frame = clamp_factor(pmbd_pkg::FACTOR_W'(f_raw))
                    * clamp_factor(pmbd_pkg::FACTOR_W'(f_raw))
                    * clamp_width(pmbd_pkg::WIDTH_W'(w_raw))
                    * clamp_height(pmbd_pkg::HEIGHT_W'(h_raw));
            n = frame * $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0)
                n += $urandom_range(1, frame);
            if (n > 250)
                n = $urandom_range(100, 250);
            run_samples(n, 12);
        end
        drain_pixels();

        $display("%0d palette loads and %0d samples sent, %0d pixels checked", n_loads,
                 n_samples, n_pixels);
        $display("over %0d register settings, out-of-range values and full-rate bursts included",
                 n_settings);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
sv/pmbd_pkg.sv
sv/pmbd_palette_ram.sv
sv/pmbd_colsum_ram.sv
sv/pmbd_position.sv
sv/pmbd_accum.sv
sv/palette_map_box_downsample.sv
sv/pmbd_checker.sv
verif/palette_map_box_downsample_tb.sv
